/* src/aff2d_pkg.sv */
// shared widths, constants and item types for the 2d affine inverse
package aff2d_pkg;

	localparam int unsigned WORD_WIDTH = 32;
	localparam int unsigned FRAC_BITS  = 16;

	// exact product and determinant width
	localparam int unsigned DW = 2 * WORD_WIDTH;
	// widest scaled numerator magnitude
	localparam int unsigned NB_LIN = WORD_WIDTH + 2 * FRAC_BITS;
	localparam int unsigned NB_TRN = DW + FRAC_BITS;
	localparam int unsigned NB = (NB_LIN > NB_TRN) ? NB_LIN : NB_TRN;
	// partial remainder width, holds the numerator and den << (WORD_WIDTH+1)
	localparam int unsigned RW_MIN = 3 * WORD_WIDTH + 2;
	localparam int unsigned RW = (NB > RW_MIN) ? NB : RW_MIN;
	// quotient bits kept before saturation
	localparam int unsigned QW = WORD_WIDTH + 1;
	localparam int unsigned NSTEP = QW;
	// divider stages: range check, one per quotient bit, rounding, saturation
	localparam int unsigned DS = NSTEP + 3;
	// whole pipeline: multiply, combine, magnitude, then the divider
	localparam int unsigned NS = DS + 3;
	localparam int unsigned NLANE = 6;

	typedef struct packed {
		logic signed [WORD_WIDTH-1:0] coef_a;
		logic signed [WORD_WIDTH-1:0] coef_b;
		logic signed [WORD_WIDTH-1:0] coef_c;
		logic signed [WORD_WIDTH-1:0] coef_d;
		logic signed [WORD_WIDTH-1:0] shift_x;
		logic signed [WORD_WIDTH-1:0] shift_y;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_WIDTH-1:0] inv_a;
		logic signed [WORD_WIDTH-1:0] inv_b;
		logic signed [WORD_WIDTH-1:0] inv_c;
		logic signed [WORD_WIDTH-1:0] inv_d;
		logic signed [WORD_WIDTH-1:0] inv_shift_x;
		logic signed [WORD_WIDTH-1:0] inv_shift_y;
		logic                         overflowed;
		logic                         singular;
	} out_item_t;

endpackage

/* src/aff2d_div.sv */
// pipelined restoring divider, one quotient bit per stage, rounding and saturation
module aff2d_div import aff2d_pkg::*; (
	input  logic                  clk,
	input  logic [DS-1:0]         en,
	input  logic [NB-1:0]         num,
	input  logic [DW-1:0]         den,
	input  logic                  neg,
	output logic [WORD_WIDTH-1:0] res,
	output logic                  ovf
);

	logic [RW-1:0] rem_p [0:NSTEP];
	logic [DW-1:0] den_p [0:NSTEP];
	logic [QW-1:0] quo_p [0:NSTEP];
	logic          neg_p [0:NSTEP];
	logic          big_p [0:NSTEP];

	logic [QW:0]   qr_r;
	logic          neg_r;
	logic          big_r;

	// range check: quotient would reach 2^(WORD_WIDTH+1)
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_p[0] <= RW'(num);
			den_p[0] <= den;
			quo_p[0] <= '0;
			neg_p[0] <= neg;
			big_p[0] <= RW'(num) >= (RW'(den) << QW);
		end
	end

	for (genvar j = 1; j <= NSTEP; j++) begin : g_step
		localparam int unsigned SH = NSTEP - j;
		logic [RW:0] trial;
		assign trial = {1'b0, rem_p[j-1]} - ({1'b0, RW'(den_p[j-1])} << SH);
		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_p[j] <= trial[RW] ? rem_p[j-1] : trial[RW-1:0];
				quo_p[j] <= {quo_p[j-1][QW-2:0], ~trial[RW]};
				den_p[j] <= den_p[j-1];
				neg_p[j] <= neg_p[j-1];
				big_p[j] <= big_p[j-1];
			end
		end
	end

	// round to nearest, ties away from zero
	always_ff @(posedge clk) begin
		if (en[NSTEP+1]) begin
			qr_r  <= {1'b0, quo_p[NSTEP]}
				+ (QW+1)'({rem_p[NSTEP][DW:0], 1'b0} >= {2'b00, den_p[NSTEP]});
			neg_r <= neg_p[NSTEP];
			big_r <= big_p[NSTEP];
		end
	end

	logic [QW:0]           lim;
	logic                  sat;
	logic [WORD_WIDTH-1:0] mag;

	always_comb begin
		lim = (QW+1)'(1) << (WORD_WIDTH - 1);
		if (!neg_r) begin
			lim = lim - (QW+1)'(1);
		end
		sat = big_r || (qr_r > lim);
		mag = sat ? lim[WORD_WIDTH-1:0] : qr_r[WORD_WIDTH-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[NSTEP+2]) begin
			res <= neg_r ? (~mag + WORD_WIDTH'(1)) : mag;
			ovf <= sat;
		end
	end

endmodule

/* src/affine_2d_matrix_invert.sv */
// top level of the 2d affine inverse pipeline
// Takes one affine map (a, b, c, d, tx, ty in signed fixed point) per item and
// returns its inverse: d/det, -b/det, -c/det, a/det, (b*ty - d*tx)/det and
// (c*tx - a*ty)/det, each rounded to nearest with ties away from zero and
// saturated to the word range (overflowed set). A zero determinant is replaced
// by one least step and flagged as singular. The pipeline takes one item per
// clock while the output is not stalled. It has one stage of multipliers, one
// to combine products, one for magnitudes, then six parallel dividers, each
// producing one quotient bit per stage plus range check, rounding and
// saturation stages. Stages hold independently, so a stall at the output
// squeezes out bubbles before it reaches the input.
module affine_2d_matrix_invert import aff2d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	// stage valids and per-stage advance
	logic [NS:1]   vld_q;
	logic [NS+1:1] en;

	always_comb begin
		en[NS+1] = out_ready;
		for (int k = NS; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= (k == 1) ? in_valid : vld_q[(k == 1) ? 1 : k-1];
				end
			end
		end
	end

	// stage 1: the six exact products
	logic signed [DW-1:0] ad_s1, bc_s1, bty_s1, dtx_s1, ctx_s1, aty_s1;
	logic signed [WORD_WIDTH-1:0] a_s1, b_s1, c_s1, d_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ad_s1  <= in_item.coef_a * in_item.coef_d;
			bc_s1  <= in_item.coef_b * in_item.coef_c;
			bty_s1 <= in_item.coef_b * in_item.shift_y;
			dtx_s1 <= in_item.coef_d * in_item.shift_x;
			ctx_s1 <= in_item.coef_c * in_item.shift_x;
			aty_s1 <= in_item.coef_a * in_item.shift_y;
			a_s1   <= in_item.coef_a;
			b_s1   <= in_item.coef_b;
			c_s1   <= in_item.coef_c;
			d_s1   <= in_item.coef_d;
		end
	end

	// stage 2: determinant and translation numerators
	logic signed [DW:0] det_s2, nx_s2, ny_s2;
	logic signed [WORD_WIDTH-1:0] a_s2, b_s2, c_s2, d_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			det_s2 <= {ad_s1[DW-1], ad_s1} - {bc_s1[DW-1], bc_s1};
			nx_s2  <= {bty_s1[DW-1], bty_s1} - {dtx_s1[DW-1], dtx_s1};
			ny_s2  <= {ctx_s1[DW-1], ctx_s1} - {aty_s1[DW-1], aty_s1};
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			c_s2   <= c_s1;
			d_s2   <= d_s1;
		end
	end

	// stage 3: magnitudes, scaling and quotient signs
	logic [DW-1:0]         det_mag;
	logic                  det_zero;
	logic [WORD_WIDTH-1:0] ma, mb, mc, md;
	logic [DW:0]           nx_abs, ny_abs;

	always_comb begin
		det_zero = (det_s2 == '0);
		nx_abs   = nx_s2[DW] ? (~nx_s2 + (DW+1)'(1)) : nx_s2;
		ny_abs   = ny_s2[DW] ? (~ny_s2 + (DW+1)'(1)) : ny_s2;
		ma       = a_s2[WORD_WIDTH-1] ? (~a_s2 + WORD_WIDTH'(1)) : a_s2;
		mb       = b_s2[WORD_WIDTH-1] ? (~b_s2 + WORD_WIDTH'(1)) : b_s2;
		mc       = c_s2[WORD_WIDTH-1] ? (~c_s2 + WORD_WIDTH'(1)) : c_s2;
		md       = d_s2[WORD_WIDTH-1] ? (~d_s2 + WORD_WIDTH'(1)) : d_s2;
		if (det_zero) begin
			det_mag = DW'(1) << FRAC_BITS;
		end else begin
			det_mag = det_s2[DW] ? DW'(~det_s2 + (DW+1)'(1)) : det_s2[DW-1:0];
		end
	end

	logic [NB-1:0] num_s3 [0:NLANE-1];
	logic          neg_s3 [0:NLANE-1];
	logic [DW-1:0] den_s3;
	logic          sing_s3;
	logic          dneg;

	// a zero determinant becomes one positive step
	assign dneg = det_s2[DW] && !det_zero;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			num_s3[0] <= NB'(md) << (2 * FRAC_BITS);
			num_s3[1] <= NB'(mb) << (2 * FRAC_BITS);
			num_s3[2] <= NB'(mc) << (2 * FRAC_BITS);
			num_s3[3] <= NB'(ma) << (2 * FRAC_BITS);
			num_s3[4] <= NB'(nx_abs) << FRAC_BITS;
			num_s3[5] <= NB'(ny_abs) << FRAC_BITS;
			// -b and -c are negative when b and c are positive
			neg_s3[0] <= d_s2[WORD_WIDTH-1] ^ dneg;
			neg_s3[1] <= (!b_s2[WORD_WIDTH-1] && (b_s2 != '0)) ^ dneg;
			neg_s3[2] <= (!c_s2[WORD_WIDTH-1] && (c_s2 != '0)) ^ dneg;
			neg_s3[3] <= a_s2[WORD_WIDTH-1] ^ dneg;
			neg_s3[4] <= nx_s2[DW] ^ dneg;
			neg_s3[5] <= ny_s2[DW] ^ dneg;
			den_s3    <= det_mag;
			sing_s3   <= det_zero;
		end
	end

	// stages 4 onwards: six dividers in lockstep
	logic [WORD_WIDTH-1:0] res [0:NLANE-1];
	logic [NLANE-1:0]      ovf;

	for (genvar l = 0; l < NLANE; l++) begin : g_lane
		aff2d_div u_div (
			.clk (clk),
			.en  (en[NS:4]),
			.num (num_s3[l]),
			.den (den_s3),
			.neg (neg_s3[l]),
			.res (res[l]),
			.ovf (ovf[l])
		);
	end

	// singular flag follows the divider stages
	logic sing_p [0:DS-1];

	always_ff @(posedge clk) begin
		for (int k = 0; k < DS; k++) begin
			if (en[k+4]) begin
				sing_p[k] <= (k == 0) ? sing_s3 : sing_p[(k == 0) ? 0 : k-1];
			end
		end
	end

	always_comb begin
		out_item.inv_a       = res[0];
		out_item.inv_b       = res[1];
		out_item.inv_c       = res[2];
		out_item.inv_d       = res[3];
		out_item.inv_shift_x = res[4];
		out_item.inv_shift_y = res[5];
		out_item.overflowed  = |ovf;
		out_item.singular    = sing_p[DS-1];
	end

endmodule
